// ===== rtl/core/assert_macros.svh =====
// assertion macros shared by the sorted set engine modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
`define SSET_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define SSET_ASSERT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) else $error(msg);
`else
`define SSET_ASSERT(lbl, prop, msg)
`define SSET_ASSERT_NEVER(lbl, expr, msg)
`endif

`endif

// ===== rtl/core/sset_pkg.sv =====
// types and constants of the sorted set engine
package sset_pkg;

  localparam int CAPACITY_DEF     = 64;
  localparam int VALUE_BITS_DEF   = 32;
  localparam int FIELD_VALUE_BITS = 32;
  localparam int INDEX_BITS       = 6;
  localparam int COUNT_BITS       = 7;

  typedef enum logic [1:0] {
    MODE_INSERT = 2'd0,
    MODE_READ   = 2'd1,
    MODE_REMOVE = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_READ   = 2'd1,
    OP_REMOVE = 2'd2,
    OP_NOP    = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_DUP    = 2'd1,
    ST_FULL   = 2'd2,
    ST_BADIDX = 2'd3
  } status_e;

  typedef struct packed {
    logic [1:0]                         mode;
    logic signed [FIELD_VALUE_BITS-1:0] value;
    logic [INDEX_BITS-1:0]              index;
  } cmd_t;

  typedef struct packed {
    logic signed [FIELD_VALUE_BITS-1:0] read_value;
    logic [COUNT_BITS-1:0]              entry_count;
    status_e                            status;
  } rsp_t;

  typedef struct packed {
    op_e                                op;
    logic signed [FIELD_VALUE_BITS-1:0] value;
    logic [INDEX_BITS-1:0]              index;
  } job_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_status_t;

endpackage

// ===== rtl/core/sset_front.sv =====
// command intake: accepts transactions and classifies the operation
module sset_front (
  input  logic               start,
  output logic               busy,
  input  sset_pkg::cmd_t     cmd_i,
  input  sset_pkg::q_status_t q_status_i,
  output logic               push_o,
  output sset_pkg::job_t     job_o
);

  assign busy   = q_status_i.full;
  assign push_o = start && !q_status_i.full;

  always_comb begin
    job_o.value = cmd_i.value;
    job_o.index = cmd_i.index;
    case (cmd_i.mode)
      sset_pkg::MODE_INSERT: job_o.op = sset_pkg::OP_INSERT;
      sset_pkg::MODE_READ:   job_o.op = sset_pkg::OP_READ;
      sset_pkg::MODE_REMOVE: job_o.op = sset_pkg::OP_REMOVE;
      default:               job_o.op = sset_pkg::OP_NOP;
    endcase
  end

endmodule

// ===== rtl/core/sset_queue.sv =====
// two-entry queue between command intake and the set sequencer
`include "assert_macros.svh"

module sset_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  sset_pkg::job_t      job_i,
  input  logic                pop_i,
  output sset_pkg::job_t      job_o,
  output sset_pkg::q_status_t q_status_o
);

  sset_pkg::job_t slot_q [2];
  logic           wr_ptr_q, wr_ptr_d;
  logic           rd_ptr_q, rd_ptr_d;
  logic [1:0]     fill_q, fill_d;
  logic           do_pop;

  assign do_pop           = pop_i && (fill_q != 2'd0);
  assign q_status_o.empty = (fill_q == 2'd0);
  assign q_status_o.full  = (fill_q == 2'd2);
  assign job_o            = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_pop ? !rd_ptr_q : rd_ptr_q;
    fill_d   = fill_q + 2'(push_i) - 2'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= job_i;
    end
  end

  `SSET_ASSERT_NEVER(a_no_overflow, push_i && (fill_q == 2'd2), "push into full queue")

endmodule

// ===== rtl/core/sset_back.sv =====
// set sequencer: sorted entry memory with search, shift and read steps
`include "assert_macros.svh"

module sset_back #(
  parameter int CAPACITY   = sset_pkg::CAPACITY_DEF,
  parameter int VALUE_BITS = sset_pkg::VALUE_BITS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  sset_pkg::job_t      job_i,
  input  sset_pkg::q_status_t q_status_i,
  output logic                pop_o,
  output logic                done_o,
  output sset_pkg::rsp_t      rsp_o
);

  localparam int IW       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW       = $clog2(CAPACITY + 1);
  localparam int CMPW     = (CW > sset_pkg::INDEX_BITS) ? CW : sset_pkg::INDEX_BITS;
  localparam int EXT_BITS = (VALUE_BITS < sset_pkg::FIELD_VALUE_BITS) ?
                            VALUE_BITS : sset_pkg::FIELD_VALUE_BITS;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_INS  = 3'd2;
  localparam logic [2:0] S_LAST = 3'd3;
  localparam logic [2:0] S_RD   = 3'd4;
  localparam logic [2:0] S_RM   = 3'd5;

  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);
  localparam logic [CW-1:0] ONE_C = CW'(1);
  localparam logic [CW-1:0] TWO_C = CW'(2);

  logic [VALUE_BITS-1:0] mem [CAPACITY];
  logic signed [VALUE_BITS-1:0] rdata_q;

  logic [2:0]                   state_q, state_d;
  logic [CW-1:0]                count_q, count_d;
  logic [CW-1:0]                ptr_q, ptr_d;
  logic [CW-1:0]                pos_q, pos_d;
  logic signed [VALUE_BITS-1:0] val_q, val_d;
  logic                         done_q, done_d;
  sset_pkg::rsp_t               rsp_q, rsp_d;

  logic                         we;
  logic [CW-1:0]                waddr, raddr, pos_c, ix_c;
  logic [VALUE_BITS-1:0]        wdata;
  logic signed [VALUE_BITS-1:0] val_in;
  logic [CMPW-1:0]              ix_ext, cnt_ext;
  logic                         respond;
  sset_pkg::status_e            resp_st;
  logic signed [sset_pkg::FIELD_VALUE_BITS-1:0] resp_rd;

  assign val_in  = VALUE_BITS'(signed'(job_i.value[EXT_BITS-1:0]));
  assign ix_ext  = CMPW'(job_i.index);
  assign cnt_ext = CMPW'(count_q);
  assign ix_c    = CW'(ix_ext);

  always_comb begin
    state_d = state_q;
    count_d = count_q;
    ptr_d   = ptr_q;
    pos_d   = pos_q;
    val_d   = val_q;
    pop_o   = 1'b0;
    we      = 1'b0;
    waddr   = '0;
    wdata   = val_q;
    raddr   = '0;
    pos_c   = count_q;
    respond = 1'b0;
    resp_st = sset_pkg::ST_OK;
    resp_rd = '0;
    case (state_q)
      S_IDLE: begin
        if (!q_status_i.empty) begin
          pop_o = 1'b1;
          val_d = val_in;
          case (job_i.op)
            sset_pkg::OP_INSERT: begin
              if (count_q == '0) begin
                we      = 1'b1;
                wdata   = val_in;
                count_d = ONE_C;
                respond = 1'b1;
              end else begin
                ptr_d   = '0;
                state_d = S_SCAN;
              end
            end
            sset_pkg::OP_READ: begin
              if (ix_ext >= cnt_ext) begin
                respond = 1'b1;
                resp_st = sset_pkg::ST_BADIDX;
              end else begin
                raddr   = ix_c;
                state_d = S_RD;
              end
            end
            sset_pkg::OP_REMOVE: begin
              if (ix_ext >= cnt_ext) begin
                respond = 1'b1;
                resp_st = sset_pkg::ST_BADIDX;
              end else if (ix_c + ONE_C == count_q) begin
                count_d = count_q - ONE_C;
                respond = 1'b1;
              end else begin
                ptr_d   = ix_c;
                raddr   = ix_c + ONE_C;
                state_d = S_RM;
              end
            end
            default: begin
              respond = 1'b1;
            end
          endcase
        end
      end
      S_SCAN: begin
        if (rdata_q == val_q) begin
          respond = 1'b1;
          resp_st = sset_pkg::ST_DUP;
          state_d = S_IDLE;
        end else if ((rdata_q > val_q) || (ptr_q == count_q - ONE_C)) begin
          pos_c = (rdata_q > val_q) ? ptr_q : count_q;
          if (count_q == CAP_C) begin
            respond = 1'b1;
            resp_st = sset_pkg::ST_FULL;
            state_d = S_IDLE;
          end else if (pos_c == count_q) begin
            we      = 1'b1;
            waddr   = count_q;
            count_d = count_q + ONE_C;
            respond = 1'b1;
            state_d = S_IDLE;
          end else begin
            ptr_d   = count_q;
            pos_d   = pos_c;
            raddr   = count_q - ONE_C;
            state_d = S_INS;
          end
        end else begin
          ptr_d = ptr_q + ONE_C;
          raddr = ptr_q + ONE_C;
        end
      end
      S_INS: begin
        we    = 1'b1;
        waddr = ptr_q;
        wdata = rdata_q;
        if (ptr_q - ONE_C == pos_q) begin
          state_d = S_LAST;
        end else begin
          ptr_d = ptr_q - ONE_C;
          raddr = ptr_q - TWO_C;
        end
      end
      S_LAST: begin
        we      = 1'b1;
        waddr   = pos_q;
        count_d = count_q + ONE_C;
        respond = 1'b1;
        state_d = S_IDLE;
      end
      S_RD: begin
        respond = 1'b1;
        resp_rd = sset_pkg::FIELD_VALUE_BITS'(rdata_q);
        state_d = S_IDLE;
      end
      S_RM: begin
        we    = 1'b1;
        waddr = ptr_q;
        wdata = rdata_q;
        if (ptr_q + TWO_C == count_q) begin
          count_d = count_q - ONE_C;
          respond = 1'b1;
          state_d = S_IDLE;
        end else begin
          ptr_d = ptr_q + ONE_C;
          raddr = ptr_q + TWO_C;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
    done_d = respond;
    rsp_d  = rsp_q;
    if (respond) begin
      rsp_d.read_value  = resp_rd;
      rsp_d.entry_count = sset_pkg::COUNT_BITS'(count_d);
      rsp_d.status      = resp_st;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr[IW-1:0]] <= wdata;
    end
    rdata_q <= mem[raddr[IW-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ptr_q <= ptr_d;
    pos_q <= pos_d;
    val_q <= val_d;
    rsp_q <= rsp_d;
  end

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

  `SSET_ASSERT(a_count_bound, count_q <= CAP_C, "entry count above capacity")
  `SSET_ASSERT(a_pop_idle, pop_o |-> (state_q == S_IDLE), "queue popped while busy")
  `SSET_ASSERT(a_write_range, we |-> (waddr < CAP_C), "memory write out of range")
  `SSET_ASSERT(a_dup_keeps, (done_q && (rsp_q.status == sset_pkg::ST_DUP)) |-> (count_q == $past(count_q)), "duplicate changed count")
  `SSET_ASSERT(a_full_count, (done_q && (rsp_q.status == sset_pkg::ST_FULL)) |-> (count_q == CAP_C), "full status with spare room")

endmodule

// ===== rtl/core/sorted_unique_set_engine_core.sv =====
// top level of the sorted unique set engine
// A transaction is taken when start is high and busy is low; a two-entry queue
// lets commands be taken while the sequencer works. Each transaction gives one
// result, shown for a single cycle with done_o high, which must be captured then.
// Work per command runs on one entry memory with a write port and a registered
// read port: a read looks up the entry and then answers, a bad index or unused
// mode is answered at once, an insert compares entries up to and including the
// first equal or larger one (or all of them), then, when entries move, moves
// each larger entry up by one and places the value, and a remove moves each
// entry above the removed one down by one. A transaction waits in the queue
// until the sequencer is idle; its result is registered from the last work step.
// The entry memory needs no clearing pass after reset.
module sorted_unique_set_engine_core #(
  parameter int CAPACITY   = sset_pkg::CAPACITY_DEF,
  parameter int VALUE_BITS = sset_pkg::VALUE_BITS_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  output logic           busy,
  input  sset_pkg::cmd_t cmd_i,
  output logic           done_o,
  output sset_pkg::rsp_t rsp_o
);

  sset_pkg::q_status_t q_status;
  sset_pkg::job_t      in_job, head_job;
  logic                push, pop;

  sset_front u_front (
    .start      (start),
    .busy       (busy),
    .cmd_i      (cmd_i),
    .q_status_i (q_status),
    .push_o     (push),
    .job_o      (in_job)
  );

  sset_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .job_i      (in_job),
    .pop_i      (pop),
    .job_o      (head_job),
    .q_status_o (q_status)
  );

  sset_back #(
    .CAPACITY   (CAPACITY),
    .VALUE_BITS (VALUE_BITS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .job_i      (head_job),
    .q_status_i (q_status),
    .pop_o      (pop),
    .done_o     (done_o),
    .rsp_o      (rsp_o)
  );

endmodule
